// ===== src/selective_repeat_sender_assert.svh =====
// Assertion macros for the selective repeat sender.
`ifndef SELECTIVE_REPEAT_SENDER_ASSERT_SVH
`define SELECTIVE_REPEAT_SENDER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SRS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define SRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/srs_pkg.sv =====
package srs_pkg;

  localparam int WINDOW       = 4;
  localparam int SEQ_SPACE    = 8;
  localparam int PAYLOAD_BITS = 32;

  localparam int SEQ_W   = 3;
  localparam int PAY_W   = 32;
  localparam int STORE_W = (PAYLOAD_BITS < PAY_W) ? PAYLOAD_BITS : PAY_W;
  localparam int SLOT_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int OCC_W   = $clog2(WINDOW + 1);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [SEQ_W-1:0]   seq_t;
  typedef logic [STORE_W-1:0] store_t;
  typedef logic [SLOT_W-1:0]  slot_t;
  typedef logic [OCC_W-1:0]   occ_t;

  localparam occ_t             WIN_OCC = OCC_W'(WINDOW);
  localparam logic [SEQ_W:0]   SEQ_LIM = (SEQ_W + 1)'(SEQ_SPACE);
  localparam logic [OCC_W:0]   WIN_EXT = (OCC_W + 1)'(WINDOW);

  localparam logic [1:0] ACT_SEND    = 2'd0;
  localparam logic [1:0] ACT_ACK     = 2'd1;
  localparam logic [1:0] ACT_TIMEOUT = 2'd2;
  localparam logic [1:0] ACT_RSVD    = 2'd3;

  typedef enum logic [2:0] {
    EV_REFUSED = 3'd0,
    EV_SENT    = 3'd1,
    EV_ACK_OK  = 3'd2,
    EV_ACK_IGN = 3'd3,
    EV_RETX    = 3'd4,
    EV_TMO_IGN = 3'd5
  } ev_kind_t;

  typedef enum logic [2:0] {
    OP_SEND,
    OP_ACK,
    OP_ACK_BAD,
    OP_TMO,
    OP_NOP
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SEARCH,
    ST_SLIDE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [1:0]       action;
    logic [PAY_W-1:0] payload_word;
    seq_t             seq_number;
    logic             checksum_ok;
  } in_item_t;

  typedef struct packed {
    ev_kind_t         event_kind;
    seq_t             packet_seq;
    logic [PAY_W-1:0] packet_payload;
    logic             window_full;
    seq_t             window_base;
  } out_item_t;

  typedef struct packed {
    op_t    op;
    store_t payload;
    seq_t   seq;
  } req_t;

  function automatic slot_t slot_add(slot_t head, occ_t pos);
    logic [OCC_W:0] s;
    s = (OCC_W + 1)'(head) + (OCC_W + 1)'(pos);
    if (s >= WIN_EXT) begin
      s = s - WIN_EXT;
    end
    return SLOT_W'(s);
  endfunction

  function automatic seq_t seq_inc(seq_t x);
    logic [SEQ_W:0] s;
    s = {1'b0, x} + (SEQ_W + 1)'(1);
    if (s == SEQ_LIM) begin
      s = '0;
    end
    return s[SEQ_W-1:0];
  endfunction

endpackage

// ===== src/srs_front.sv =====
module srs_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  srs_pkg::in_item_t  in_data,
  output logic               q_valid,
  input  logic               q_pop,
  output srs_pkg::req_t      q_data
);
  import srs_pkg::*;

  req_t               fifo_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  cnt_r, cnt_nxt;
  req_t               cls;
  logic               push, pop;

  // classify the request
  always_comb begin
    cls.payload = in_data.payload_word[STORE_W-1:0];
    cls.seq     = in_data.seq_number;
    unique case (in_data.action)
      ACT_SEND:    cls.op = OP_SEND;
      ACT_ACK:     cls.op = in_data.checksum_ok ? OP_ACK : OP_ACK_BAD;
      ACT_TIMEOUT: cls.op = OP_TMO;
      default:     cls.op = OP_NOP;
    endcase
  end

  assign in_ready = (cnt_r != QCNT_W'(QUEUE_DEPTH));
  assign q_valid  = (cnt_r != '0);
  assign q_data   = fifo_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= cls;
    end
  end

endmodule

// ===== src/srs_back.sv =====
module srs_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_pop,
  input  srs_pkg::req_t      q_data,
  output logic               out_valid,
  input  logic               out_ready,
  output srs_pkg::out_item_t out_data
);
  import srs_pkg::*;

  state_t     state_r, state_nxt;
  req_t       cur_r, cur_nxt;
  occ_t       pos_r, pos_nxt;
  slot_t      head_r, head_nxt;
  occ_t       occ_r, occ_nxt;
  seq_t       base_r, base_nxt;
  seq_t       next_r, next_nxt;
  ev_kind_t   kind_r, kind_nxt;
  seq_t       rseq_r, rseq_nxt;
  store_t     rpay_r, rpay_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_data_r, out_data_nxt;
  logic       acked_r [WINDOW];

  store_t     pay_mem [WINDOW];
  seq_t       seq_mem [WINDOW];

  slot_t      rd_slot, wr_slot;
  logic       wr_en, ack_set, ack_clr;
  logic       full, hit, at_end, out_free;

  assign rd_slot  = slot_add(head_r, pos_r);
  assign wr_slot  = slot_add(head_r, occ_r);
  assign full     = (occ_r == WIN_OCC);
  assign at_end   = (pos_r == occ_r);
  assign hit      = (seq_mem[rd_slot] == cur_r.seq);
  assign out_free = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          priority case (q_data.op)
            OP_SEND:        state_nxt = ST_EXEC;
            OP_ACK, OP_TMO: state_nxt = ST_SEARCH;
            default:        state_nxt = ST_FINISH;
          endcase
        end
      end
      ST_EXEC: state_nxt = ST_FINISH;
      ST_SEARCH: begin
        if (at_end) begin
          state_nxt = ST_FINISH;
        end else if (hit) begin
          state_nxt = (cur_r.op == OP_ACK && pos_r == '0) ? ST_SLIDE : ST_FINISH;
        end
      end
      ST_SLIDE: begin
        if (!(occ_r != '0 && acked_r[head_r])) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cur_nxt       = cur_r;
    pos_nxt       = pos_r;
    head_nxt      = head_r;
    occ_nxt       = occ_r;
    base_nxt      = base_r;
    next_nxt      = next_r;
    kind_nxt      = kind_r;
    rseq_nxt      = rseq_r;
    rpay_nxt      = rpay_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    q_pop         = 1'b0;
    wr_en         = 1'b0;
    ack_set       = 1'b0;
    ack_clr       = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          cur_nxt  = q_data;
          pos_nxt  = '0;
          rseq_nxt = q_data.seq;
          rpay_nxt = '0;
          kind_nxt = (q_data.op == OP_ACK_BAD) ? EV_ACK_IGN : EV_TMO_IGN;
        end
      end
      ST_EXEC: begin
        if (full) begin
          kind_nxt = EV_REFUSED;
          rseq_nxt = '0;
        end else begin
          wr_en    = 1'b1;
          occ_nxt  = occ_r + OCC_W'(1);
          next_nxt = seq_inc(next_r);
          kind_nxt = EV_SENT;
          rseq_nxt = next_r;
          rpay_nxt = cur_r.payload;
        end
      end
      ST_SEARCH: begin
        if (at_end) begin
          kind_nxt = (cur_r.op == OP_ACK) ? EV_ACK_IGN : EV_TMO_IGN;
        end else if (hit) begin
          if (cur_r.op == OP_ACK) begin
            kind_nxt = EV_ACK_OK;
            ack_set  = 1'b1;
          end else begin
            kind_nxt = EV_RETX;
            rpay_nxt = pay_mem[rd_slot];
          end
        end else begin
          pos_nxt = pos_r + OCC_W'(1);
        end
      end
      ST_SLIDE: begin
        if (occ_r != '0 && acked_r[head_r]) begin
          ack_clr  = 1'b1;
          head_nxt = slot_add(head_r, OCC_W'(1));
          occ_nxt  = occ_r - OCC_W'(1);
          base_nxt = seq_inc(base_r);
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.event_kind     = kind_r;
          out_data_nxt.packet_seq     = rseq_r;
          out_data_nxt.packet_payload = PAY_W'(rpay_r);
          out_data_nxt.window_full    = full;
          out_data_nxt.window_base    = base_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      occ_r       <= '0;
      base_r      <= '0;
      next_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      occ_r       <= occ_nxt;
      base_r      <= base_nxt;
      next_r      <= next_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    pos_r      <= pos_nxt;
    kind_r     <= kind_nxt;
    rseq_r     <= rseq_nxt;
    rpay_r     <= rpay_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WINDOW; i++) begin
        acked_r[i] <= 1'b0;
      end
    end else if (wr_en) begin
      acked_r[wr_slot] <= 1'b0;
    end else if (ack_set) begin
      acked_r[rd_slot] <= 1'b1;
    end else if (ack_clr) begin
      acked_r[head_r] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      pay_mem[wr_slot] <= cur_r.payload;
      seq_mem[wr_slot] <= next_r;
    end
  end

endmodule

// ===== src/selective_repeat_sender.sv =====
// Channel  Ports                          Moves
// in       in_valid/in_ready/in_data      send, ack or timeout request
// out      out_valid/out_ready/out_data   one event per request, in order
//
// A send passes through the execute and finish states; an ack or timeout searches the window
// from the oldest entry to its match, and an ack of the oldest then slides out each retired entry.
// The window search and slide step one entry a cycle in the back sequencer.
// A two-entry request queue takes up to two requests while the back end is busy.
// rst_n is synchronous; it empties the window and queue.
`include "selective_repeat_sender_assert.svh"

module selective_repeat_sender (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  srs_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output srs_pkg::out_item_t out_data
);
  import srs_pkg::*;

  logic q_valid;
  logic q_pop;
  req_t q_data;

  srs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_data   (q_data)
  );

  srs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_data    (q_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  `SRS_ASSERT_NOW(a_refused_full, out_valid && out_data.event_kind == EV_REFUSED,
    out_data.window_full && out_data.packet_seq == '0, "refused send with open window")
  `SRS_ASSERT_NOW(a_ignored_nopay, out_valid && (out_data.event_kind == EV_ACK_IGN ||
    out_data.event_kind == EV_TMO_IGN || out_data.event_kind == EV_ACK_OK),
    out_data.packet_payload == '0, "payload on event without packet")
  `SRS_ASSERT_NEXT(a_push_queued, in_valid && in_ready, q_valid, "accepted request lost")
  `SRS_ASSERT_NOW(a_pop_valid, q_pop, q_valid, "pop from empty queue")

endmodule

// ===== tb/tb_selective_repeat_sender.sv =====
module tb_selective_repeat_sender;
  import srs_pkg::*;

  localparam int NUM_RANDOM = 1900;
  localparam int IDLE_LIMIT = 4000;
  localparam int TAIL_CYCLES = 40;

  logic      clk;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  selective_repeat_sender dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // window model
  logic [PAY_W-1:0] win_pay[WINDOW];
  seq_t             win_seq[WINDOW];
  logic             win_acked[WINDOW];
  int               win_head = 0;
  int               win_occ = 0;
  seq_t             win_base = '0;
  seq_t             win_next = '0;

  in_item_t  pending_reqs[$];
  out_item_t expected_events[$];
  int        mismatches = 0;
  int        idle_cycles = 0;

  // driver state
  int   burst_left = 0;
  int   gap_left = 0;
  logic drv_valid;

  // receiver state
  int rx_mode = 0;
  int rx_left = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic out_item_t predict_event(in_item_t req);
    out_item_t ev;
    int        pos;
    int        n;
    ev = '0;
    ev.event_kind = EV_TMO_IGN;
    ev.packet_seq = req.seq_number;
    pos = win_occ;
    for (int i = win_occ - 1; i >= 0; i--) begin
      if (win_seq[(win_head + i) % WINDOW] == req.seq_number) begin
        pos = i;
      end
    end
    case (req.action)
      ACT_SEND: begin
        if (win_occ >= WINDOW) begin
          ev.event_kind = EV_REFUSED;
          ev.packet_seq = '0;
        end else begin
          n = (win_head + win_occ) % WINDOW;
          win_pay[n] = req.payload_word;
          win_seq[n] = win_next;
          win_acked[n] = 1'b0;
          win_occ++;
          ev.event_kind = EV_SENT;
          ev.packet_seq = win_next;
          ev.packet_payload = req.payload_word;
          win_next = seq_t'((int'(win_next) + 1) % SEQ_SPACE);
        end
      end
      ACT_ACK: begin
        if (req.checksum_ok && pos < win_occ) begin
          ev.event_kind = EV_ACK_OK;
          win_acked[(win_head + pos) % WINDOW] = 1'b1;
          if (pos == 0) begin
            n = 0;
            while (n < win_occ && win_acked[(win_head + n) % WINDOW]) begin
              win_acked[(win_head + n) % WINDOW] = 1'b0;
              n++;
            end
            win_head = (win_head + n) % WINDOW;
            win_occ -= n;
            win_base = seq_t'((int'(win_base) + n) % SEQ_SPACE);
          end
        end else begin
          ev.event_kind = EV_ACK_IGN;
        end
      end
      ACT_TIMEOUT: begin
        if (pos < win_occ) begin
          ev.event_kind = EV_RETX;
          ev.packet_payload = win_pay[(win_head + pos) % WINDOW];
        end
      end
      default: ;
    endcase
    ev.window_full = (win_occ >= WINDOW);
    ev.window_base = win_base;
    return ev;
  endfunction

  task automatic push_req(logic [1:0] act, logic [PAY_W-1:0] pay, seq_t sq, logic ck);
    in_item_t r;
    r.action = act;
    r.payload_word = pay;
    r.seq_number = sq;
    r.checksum_ok = ck;
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  task automatic push_random_req();
    int               pick;
    seq_t             sq;
    logic [PAY_W-1:0] pay;
    logic [1:0]       act;
    logic             ck;
    pick = $urandom_range(0, 9);
    pay = (pick == 0) ? '0 : (pick == 1) ? '1 : PAY_W'($urandom);
    if ($urandom_range(0, 4) != 0) begin
      sq = seq_t'(int'(win_base) + $urandom_range(0, win_occ));
    end else begin
      sq = seq_t'($urandom_range(0, 7));
    end
    ck = 1'b1;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      act = ACT_SEND;
      ck = 1'($urandom_range(0, 1));
    end else if (pick < 75) begin
      act = ACT_ACK;
    end else if (pick < 80) begin
      act = ACT_ACK;
      ck = 1'b0;
    end else if (pick < 95) begin
      act = ACT_TIMEOUT;
      ck = 1'($urandom_range(0, 1));
    end else begin
      act = ACT_RSVD;
      ck = 1'($urandom_range(0, 1));
    end
    push_req(act, pay, sq, ck);
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_valid || expected_events.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // driver: bursts of requests separated by random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_events.insert(expected_events.size(), predict_event(in_data));
      end
      if (!in_valid || in_ready) begin
        drv_valid = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_reqs.size() != 0) begin
          in_data <= pending_reqs.pop_front();
          drv_valid = 1'b1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
          end
          burst_left--;
          if (burst_left == 0) begin
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
          end
        end
        in_valid <= drv_valid;
      end
    end
  end

  // monitor: check results, receiver stalls on a mode pattern
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_events.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected event: kind=%0d seq=%0d pay=%h full=%b base=%0d",
                   out_data.event_kind, out_data.packet_seq, out_data.packet_payload,
                   out_data.window_full, out_data.window_base);
        end
      end else begin
        automatic out_item_t exp_ev = expected_events.pop_front();
        if (out_data.event_kind !== exp_ev.event_kind ||
            out_data.packet_seq !== exp_ev.packet_seq ||
            out_data.packet_payload !== exp_ev.packet_payload ||
            out_data.window_full !== exp_ev.window_full ||
            out_data.window_base !== exp_ev.window_base) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("event mismatch: exp kind=%0d seq=%0d pay=%h full=%b base=%0d",
                     exp_ev.event_kind, exp_ev.packet_seq, exp_ev.packet_payload,
                     exp_ev.window_full, exp_ev.window_base);
            $display("                got kind=%0d seq=%0d pay=%h full=%b base=%0d",
                     out_data.event_kind, out_data.packet_seq, out_data.packet_payload,
                     out_data.window_full, out_data.window_base);
          end
        end
      end
    end
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_left = $urandom_range(20, 200);
    end
    rx_left--;
    case (rx_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= ($urandom_range(0, 15) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("** selective_repeat_sender: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // fill the window, then one refused send
    push_req(ACT_SEND, '1, 3'd7, 1'b1);
    push_req(ACT_SEND, '0, 3'd0, 1'b0);
    push_req(ACT_SEND, 32'hA5A5_A5A5, 3'd5, 1'b1);
    push_req(ACT_SEND, 32'h5A5A_5A5A, 3'd2, 1'b0);
    push_req(ACT_SEND, 32'h1234_5678, 3'd1, 1'b1);
    // ack out of order, repeated, bad checksum, no match
    push_req(ACT_ACK, '0, 3'd2, 1'b1);
    push_req(ACT_ACK, '1, 3'd2, 1'b1);
    push_req(ACT_ACK, '0, 3'd0, 1'b0);
    push_req(ACT_ACK, '0, 3'd7, 1'b1);
    // retransmits, acked-but-unretired retransmit, ignored timeout, unused action
    push_req(ACT_TIMEOUT, '0, 3'd1, 1'b0);
    push_req(ACT_TIMEOUT, '1, 3'd2, 1'b1);
    push_req(ACT_TIMEOUT, '0, 3'd6, 1'b0);
    push_req(ACT_RSVD, '1, 3'd5, 1'b1);
    // slides
    push_req(ACT_ACK, '0, 3'd0, 1'b1);
    push_req(ACT_ACK, '0, 3'd1, 1'b1);
    push_req(ACT_SEND, 32'h8000_0001, 3'd0, 1'b0);
    push_req(ACT_SEND, 32'h7FFF_FFFE, 3'd0, 1'b1);
    push_req(ACT_SEND, 32'hDEAD_BEEF, 3'd0, 1'b0);
    push_req(ACT_ACK, '0, 3'd6, 1'b1);
    push_req(ACT_ACK, '0, 3'd5, 1'b1);
    push_req(ACT_ACK, '0, 3'd4, 1'b1);
    push_req(ACT_ACK, '0, 3'd3, 1'b1);
    push_req(ACT_TIMEOUT, '0, 3'd3, 1'b1);
    push_req(ACT_ACK, '0, 3'd3, 1'b1);
    wait_drained();

    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i == NUM_RANDOM / 2) begin
        wait_drained();
      end
      while (pending_reqs.size() >= 2) begin
        @(posedge clk);
      end
      push_random_req();
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_events.size() != 0) begin
      mismatches++;
      $display("%0d expected events never arrived", expected_events.size());
    end
    if (mismatches == 0) begin
      $display("** selective_repeat_sender: PASSED **");
    end else begin
      $display("** selective_repeat_sender: FAILED **");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/srs_pkg.sv
src/srs_front.sv
src/srs_back.sv
src/selective_repeat_sender.sv
tb/tb_selective_repeat_sender.sv
